@@ rtl/gcsa_pkg.sv @@
// Shared constants, codes and types of the glyph cache shelf atlas allocator.
package gcsa_pkg;

  localparam int CACHE_ENTRIES = 256;
  localparam int COORD_BITS    = 13;
  localparam int CODE_BITS     = 16;
  localparam int PAD_BITS      = 4;
  localparam int ADDR_BITS     = $clog2(CACHE_ENTRIES);
  localparam int CNT_BITS      = ADDR_BITS + 1;
  // w + 2*pad and cursor + padded width need two more bits than a coordinate
  localparam int SUM_BITS      = COORD_BITS + 2;

  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = COORD_BITS;

  localparam int IN_BITS        = CODE_BITS + 2 * COORD_BITS;
  localparam int IN_TDATA_BITS  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS       = 4 * COORD_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;
  localparam int STATUS_BITS    = 2;

  typedef logic [COORD_BITS-1:0] coord_t;

  // result status codes
  localparam logic [STATUS_BITS-1:0] ST_HIT      = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_PLACED   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_NO_SPACE = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_FULL     = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ATLAS_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PAD_PIXELS   = 2'd2;

  typedef struct packed {
    coord_t u;
    coord_t v;
    coord_t w;
    coord_t h;
  } place_t;

  typedef struct packed {
    logic [CODE_BITS-1:0] code;
    place_t               place;
  } entry_t;

  typedef struct packed {
    coord_t              atlas_width;
    coord_t              atlas_height;
    logic [PAD_BITS-1:0] pad;
  } shelf_cfg_t;

  typedef struct packed {
    logic   ok;
    coord_t u;
    coord_t v;
  } fit_t;

endpackage

@@ rtl/gcsa_table.sv @@
// Glyph table memory: one write port, one registered read port.
module gcsa_table import gcsa_pkg::*; (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output entry_t               rd_data,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  entry_t               wr_data
);

  entry_t mem [CACHE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/gcsa_shelf.sv @@
// Shelf packer: shelf registers and placement of one padded rectangle.
module gcsa_shelf import gcsa_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  shelf_cfg_t cfg,
  input  coord_t     glyph_width,
  input  coord_t     glyph_height,
  input  logic       commit,
  output fit_t       fit
);

  coord_t cursor;
  coord_t top;
  coord_t bottom;

  logic [SUM_BITS-1:0] pad_x;
  logic [SUM_BITS-1:0] pad2;
  logic [SUM_BITS-1:0] pw;
  logic [SUM_BITS-1:0] ph;
  logic [SUM_BITS-1:0] cur_end;
  logic [SUM_BITS-1:0] top_end;
  logic                wrap;
  coord_t              cur_eff;
  coord_t              top_eff;

  always_comb begin
    pad_x   = SUM_BITS'(cfg.pad);
    pad2    = pad_x << 1;
    pw      = SUM_BITS'(glyph_width) + pad2;
    ph      = SUM_BITS'(glyph_height) + pad2;
    // row overflow opens a new, empty shelf under the current one
    wrap    = (SUM_BITS'(cursor) + pw) > SUM_BITS'(cfg.atlas_width);
    cur_eff = wrap ? '0 : cursor;
    top_eff = wrap ? bottom : top;
    cur_end = SUM_BITS'(cur_eff) + pw;
    top_end = SUM_BITS'(top_eff) + ph;
    fit.ok  = !(pw > SUM_BITS'(cfg.atlas_width)) &&
              !(top_end > SUM_BITS'(cfg.atlas_height));
    fit.u   = cur_eff + COORD_BITS'(cfg.pad);
    fit.v   = top_eff + COORD_BITS'(cfg.pad);
  end

  // the wrap is kept even when the rectangle then fails to fit
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor <= '0;
      top    <= '0;
      bottom <= '0;
    end else if (commit) begin
      cursor <= fit.ok ? cur_end[COORD_BITS-1:0] : cur_eff;
      top    <= top_eff;
      if (fit.ok && (top_end > SUM_BITS'(bottom))) begin
        bottom <= top_end[COORD_BITS-1:0];
      end
    end
  end

endmodule

@@ rtl/glyph_cache_shelf_atlas_allocator.sv @@
// Top level: glyph cache with linear table search and shelf-packed atlas allocation.
// Sequence: the search reads entries from 0; a hit ends it and the result goes to the output
//   register, while a miss reads every entry, then places the glyph and loads the output.
// Throughput: one item at a time, so the next item is taken only after the result is loaded
//   into the output register; the table read port, one entry per cycle, sets the search time.
// Reset: control, entry count and shelf state clear; registers return to 512/512/1.
//   Table contents are not cleared; only entries below the count are ever read.
module glyph_cache_shelf_atlas_allocator import gcsa_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  // input items
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // glyph_code[15:0], glyph_width[28:16], glyph_height[41:29], zero fill above
  input  logic [IN_TDATA_BITS-1:0]  s_tdata,
  // result items
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // place_u[12:0], place_v[25:13], stored_width[38:26], stored_height[51:39], zero fill
  output logic [OUT_TDATA_BITS-1:0] m_tdata,
  // status[1:0]
  output logic [STATUS_BITS-1:0]    m_tuser,
  // configuration writes
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEARCH = 2'd1;
  localparam logic [1:0] S_MISS   = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  localparam coord_t              RST_ATLAS_WIDTH  = COORD_BITS'(512);
  localparam coord_t              RST_ATLAS_HEIGHT = COORD_BITS'(512);
  localparam logic [PAD_BITS-1:0] RST_PAD          = PAD_BITS'(1);

  logic [1:0]           state;
  shelf_cfg_t           cfg;

  // accepted item
  logic [CODE_BITS-1:0] key_code;
  coord_t               key_width;
  coord_t               key_height;

  // search pointer and read-pending flag (read data arrives in the cycle after the read)
  logic [CNT_BITS-1:0]  issue_idx;
  logic                 chk_valid;
  logic [CNT_BITS-1:0]  count;

  // result waiting for the output register
  logic [STATUS_BITS-1:0] res_status;
  place_t                 res_place;

  logic                 accept;
  logic                 hit;
  logic                 more;
  logic                 full;
  logic                 rd_en;
  entry_t               rd_data;
  logic                 wr_en;
  entry_t               wr_data;
  logic                 commit;
  fit_t                 fit;
  logic                 out_load;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  // configuration registers; written only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.atlas_width  <= RST_ATLAS_WIDTH;
      cfg.atlas_height <= RST_ATLAS_HEIGHT;
      cfg.pad          <= RST_PAD;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ATLAS_WIDTH:  cfg.atlas_width  <= cfg_data[COORD_BITS-1:0];
        REG_ATLAS_HEIGHT: cfg.atlas_height <= cfg_data[COORD_BITS-1:0];
        REG_PAD_PIXELS:   cfg.pad          <= cfg_data[PAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // search: entries 0..count-1, one read issued per cycle, each compared in the next cycle
  assign hit   = chk_valid && (rd_data.code == key_code);
  assign more  = issue_idx < count;
  assign full  = (count == CNT_BITS'(CACHE_ENTRIES));
  assign rd_en = (state == S_SEARCH) && more && !hit;

  // table writes happen only in the miss cycle, never next to a read of the same entry
  assign commit        = (state == S_MISS) && !full;
  assign wr_en         = commit && fit.ok;
  assign wr_data.code  = key_code;
  assign wr_data.place = '{u: fit.u, v: fit.v, w: key_width, h: key_height};

  gcsa_table u_table (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (issue_idx[ADDR_BITS-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_BITS-1:0]),
    .wr_data (wr_data)
  );

  gcsa_shelf u_shelf (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .glyph_width  (key_width),
    .glyph_height (key_height),
    .commit       (commit),
    .fit          (fit)
  );

  // item payload, held for the whole search
  always_ff @(posedge clk) begin
    if (accept) begin
      key_code   <= s_tdata[CODE_BITS-1:0];
      key_width  <= s_tdata[CODE_BITS +: COORD_BITS];
      key_height <= s_tdata[CODE_BITS+COORD_BITS +: COORD_BITS];
    end
  end

  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issue_idx <= '0;
      chk_valid <= 1'b0;
      count     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            issue_idx <= '0;
            chk_valid <= 1'b0;
            state     <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (hit) begin
            chk_valid <= 1'b0;
            state     <= S_DONE;
          end else if (more) begin
            issue_idx <= issue_idx + 1'b1;
            chk_valid <= 1'b1;
          end else begin
            chk_valid <= 1'b0;
            state     <= S_MISS;
          end
        end
        S_MISS: begin
          if (wr_en) begin
            count <= count + 1'b1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register; failures carry zero placement
  always_ff @(posedge clk) begin
    if ((state == S_SEARCH) && hit) begin
      res_status <= ST_HIT;
      res_place  <= rd_data.place;
    end else if (state == S_MISS) begin
      if (full) begin
        res_status <= ST_FULL;
        res_place  <= '0;
      end else if (fit.ok) begin
        res_status <= ST_PLACED;
        res_place  <= wr_data.place;
      end else begin
        res_status <= ST_NO_SPACE;
        res_place  <= '0;
      end
    end
  end

  // output register: holds a result while the next item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tuser <= res_status;
      m_tdata <= OUT_TDATA_BITS'({res_place.h, res_place.w, res_place.v, res_place.u});
    end
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(CACHE_ENTRIES))
    else $error("entry count beyond table size");

  a_write_counts: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (count == $past(count) + 1'b1))
    else $error("table write without count advance");

  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_SEARCH) && (issue_idx == '0) && !chk_valid)
    else $error("accepted item did not start a search");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == S_DONE))
    else $error("result shown without a finished item");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (issue_idx < count))
    else $error("table read beyond written entries");

endmodule
